[hw/rtl/assert_macros.svh]
// Concurrent assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge of clk, skipped while rst_n is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check prop at every rising edge of clk, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

[hw/rtl/c2dv_pkg.sv]
`timescale 1ns / 1ps

package c2dv_pkg;

    localparam int KDIM_DEF      = 3;
    localparam int MAX_WIDTH_DEF = 8192;

    localparam int PIX_W       = 8;
    localparam int COEF_W      = 16;
    localparam int PROD_W      = PIX_W + 1 + COEF_W;
    localparam int SUM_W       = 28;
    localparam int COL_W       = 13;
    localparam int ROW_W       = 14;
    localparam int DIM_W       = 14;
    localparam int CFG_ADDR_W  = 3;
    localparam int CFG_DATA_W  = 64;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 32;

    localparam logic [DIM_W-1:0] WIDTH_RST  = 14'd7680;
    localparam logic [DIM_W-1:0] HEIGHT_RST = 14'd4320;
    localparam logic [ROW_W-1:0] ROW_SAT    = '1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_COEF_ROW0    = 3'd2,
        CFG_COEF_ROW1    = 3'd3,
        CFG_COEF_ROW2    = 3'd4,
        CFG_COEF_ROW3    = 3'd5
    } cfg_index_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic shift_en;
        logic prod_en;
        logic sum_en;
    } cell_ctl_t;

endpackage

[hw/rtl/c2dv_ram.sv]
`timescale 1ns / 1ps

module c2dv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/c2dv_cell.sv]
`timescale 1ns / 1ps

module c2dv_cell #(
    parameter int KDIM      = c2dv_pkg::KDIM_DEF,
    parameter int MAX_WIDTH = c2dv_pkg::MAX_WIDTH_DEF,
    parameter bit HAS_LINE  = 1'b1
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  c2dv_pkg::cell_ctl_t                 ctl,
    input  logic [$clog2(MAX_WIDTH)-1:0]        rd_addr,
    input  logic [$clog2(MAX_WIDTH)-1:0]        wr_addr,
    input  logic [c2dv_pkg::PIX_W-1:0]          v_in,
    output logic [c2dv_pkg::PIX_W-1:0]          v_out,
    input  logic [c2dv_pkg::CFG_DATA_W-1:0]     coef_row,
    output logic signed [c2dv_pkg::SUM_W-1:0]   row_sum
);

    logic [c2dv_pkg::PIX_W-1:0]         win_reg [KDIM];
    logic signed [c2dv_pkg::PROD_W-1:0] prod_reg [KDIM];
    logic signed [c2dv_pkg::SUM_W-1:0]  acc;
    logic signed [c2dv_pkg::SUM_W-1:0]  row_sum_reg;

    generate
        if (HAS_LINE) begin : g_line
            c2dv_ram #(
                .WIDTH (c2dv_pkg::PIX_W),
                .DEPTH (MAX_WIDTH)
            ) u_line (
                .clk   (aclk),
                .we    (ctl.wr_en),
                .waddr (wr_addr),
                .wdata (v_in),
                .re    (ctl.rd_en),
                .raddr (rd_addr),
                .rdata (v_out)
            );
        end else begin : g_pass
            assign v_out = v_in;
        end
    endgenerate

    // shift the window row left, new column enters on the right
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int j = 0; j < KDIM; j++) begin
                win_reg[j] <= '0;
            end
        end else if (ctl.shift_en) begin
            for (int j = 0; j + 1 < KDIM; j++) begin
                win_reg[j] <= win_reg[j + 1];
            end
            win_reg[KDIM-1] <= v_out;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            for (int j = 0; j < KDIM; j++) begin
                prod_reg[j] <= $signed({1'b0, win_reg[j]})
                             * $signed(coef_row[c2dv_pkg::COEF_W*j +: c2dv_pkg::COEF_W]);
            end
        end
    end

    always_comb begin
        acc = '0;
        for (int j = 0; j < KDIM; j++) begin
            acc = acc + c2dv_pkg::SUM_W'(prod_reg[j]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.sum_en) begin
            row_sum_reg <= acc;
        end
    end

    assign row_sum = row_sum_reg;

endmodule

[hw/rtl/conv2d_valid_stream_top.sv]
`timescale 1ns / 1ps
// Channel  | Dir | tdata (low bit up)            | tuser / tlast
// s_       | in  | pixel[7:0]                    | tuser[0] frame_start
// m_       | out | filtered_value[27:0], 4'b0    | tlast last_of_frame
// cfg_     | in  | cfg_addr index, cfg_wdata     | -
// Sustained rate: one pixel per cycle while m_tready stays high; m_tvalid rises once the
// pixel has passed the registered stages line store read, window shift, multiply, row sum, total.
// One line store RAM per kernel row but the last; its registered read sets the
// first stage. Line store contents are not cleared after reset.
// aresetn is synchronous and clears counters, window and stage valids.
// Each stage holds only while full and blocked, so bubbles keep s_tready high.

module conv2d_valid_stream_top #(
    parameter int KDIM      = c2dv_pkg::KDIM_DEF,
    parameter int MAX_WIDTH = c2dv_pkg::MAX_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [c2dv_pkg::TDATA_IN_W-1:0]     s_tdata,   // pixel[7:0]
    input  logic [0:0]                          s_tuser,   // frame_start
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [c2dv_pkg::TDATA_OUT_W-1:0]    m_tdata,   // filtered_value[27:0], zero pad
    output logic                                m_tlast,
    input  logic                                cfg_we,
    input  logic [c2dv_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [c2dv_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int DW = c2dv_pkg::DIM_W;
    localparam logic [DW-1:0] MAXW_D    = DW'(MAX_WIDTH);
    localparam logic [DW-1:0] KSZ_D     = DW'(KDIM);
    localparam logic [DW-1:0] KM1_D     = DW'(KDIM - 1);
    localparam logic [AW-1:0] ADDR_LAST = AW'(MAX_WIDTH - 1);

    logic [DW-1:0]                     width_reg;
    logic [DW-1:0]                     height_reg;
    logic [c2dv_pkg::CFG_DATA_W-1:0]   coef_reg [KDIM];

    logic [c2dv_pkg::COL_W-1:0]        col_reg, col_next, col;
    logic [c2dv_pkg::ROW_W-1:0]        row_reg, row_next, row;
    logic [DW-1:0]                     eff_w, col_d;
    logic [AW-1:0]                     rd_addr;
    logic                              has_res, is_last, row_end, accept;

    logic                              va_reg, res_a_reg, last_a_reg;
    logic [c2dv_pkg::PIX_W-1:0]        pix_a_reg;
    logic [AW-1:0]                     addr_a_reg;
    logic                              vb_reg, last_b_reg;
    logic                              vc_reg, last_c_reg;
    logic                              vd_reg, last_d_reg;
    logic                              m_tvalid_reg, m_tlast_reg;
    logic signed [c2dv_pkg::SUM_W-1:0] sum_reg, total;
    logic                              adv_a, adv_b, adv_c, adv_d, adv_e;

    c2dv_pkg::cell_ctl_t               ctl;
    logic [c2dv_pkg::PIX_W-1:0]        cell_v [KDIM];
    logic signed [c2dv_pkg::SUM_W-1:0] cell_sum [KDIM];

    // configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= c2dv_pkg::WIDTH_RST;
            height_reg <= c2dv_pkg::HEIGHT_RST;
        end else if (cfg_we) begin
            unique case (c2dv_pkg::cfg_index_t'(cfg_addr))
                c2dv_pkg::CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata[DW-1:0];
                c2dv_pkg::CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < KDIM; r++) begin
                coef_reg[r] <= '0;
            end
        end else begin
            for (int r = 0; r < KDIM; r++) begin
                if (cfg_we && cfg_addr ==
                        c2dv_pkg::CFG_ADDR_W'(int'(c2dv_pkg::CFG_COEF_ROW0) + r)) begin
                    coef_reg[r] <= cfg_wdata;
                end
            end
        end
    end

    // position tracking
    always_comb begin
        col     = s_tuser[0] ? '0 : col_reg;
        row     = s_tuser[0] ? '0 : row_reg;
        eff_w   = (width_reg > MAXW_D) ? MAXW_D : width_reg;
        col_d   = DW'(col);
        rd_addr = (col_d < MAXW_D) ? col[AW-1:0] : ADDR_LAST;
        has_res = eff_w >= KSZ_D && height_reg >= KSZ_D && row >= KM1_D &&
                  row < height_reg && col_d >= KM1_D && col_d < eff_w;
        is_last = row == height_reg - 1'b1 && col_d == eff_w - 1'b1;
        row_end = col_d + 1'b1 >= eff_w;
        if (row_end) begin
            col_next = '0;
            row_next = (row != c2dv_pkg::ROW_SAT) ? row + 1'b1 : row;
        end else begin
            col_next = col + 1'b1;
            row_next = row;
        end
    end

    // stage advance
    assign adv_e    = !m_tvalid_reg || m_tready;
    assign adv_d    = !vd_reg || adv_e;
    assign adv_c    = !vc_reg || adv_d;
    assign adv_b    = !vb_reg || adv_c;
    assign adv_a    = !va_reg || adv_b;
    assign s_tready = adv_a;
    assign accept   = s_tvalid && adv_a;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg      <= '0;
            row_reg      <= '0;
            va_reg       <= 1'b0;
            vb_reg       <= 1'b0;
            vc_reg       <= 1'b0;
            vd_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (adv_a) begin
                va_reg <= s_tvalid;
            end
            if (adv_b) begin
                vb_reg <= va_reg && res_a_reg;
            end
            if (adv_c) begin
                vc_reg <= vb_reg;
            end
            if (adv_d) begin
                vd_reg <= vc_reg;
            end
            if (adv_e) begin
                m_tvalid_reg <= vd_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            res_a_reg  <= has_res;
            last_a_reg <= is_last;
            pix_a_reg  <= s_tdata[c2dv_pkg::PIX_W-1:0];
            addr_a_reg <= rd_addr;
        end
        if (adv_b) begin
            last_b_reg <= last_a_reg;
        end
        if (adv_c) begin
            last_c_reg <= last_b_reg;
        end
        if (adv_d) begin
            last_d_reg <= last_c_reg;
        end
        if (adv_e && vd_reg) begin
            sum_reg     <= total;
            m_tlast_reg <= last_d_reg;
        end
    end

    always_comb begin
        ctl.rd_en    = accept;
        ctl.wr_en    = va_reg && adv_b;
        ctl.shift_en = va_reg && adv_b;
        ctl.prod_en  = vb_reg && adv_c;
        ctl.sum_en   = vc_reg && adv_d;
    end

    // cell k holds window row k and, below the top cell, line k; its column pixel feeds cell k-1
    generate
        for (genvar k = 0; k < KDIM; k++) begin : g_cell
            logic [c2dv_pkg::PIX_W-1:0] v_in;
            if (k == KDIM - 1) begin : g_top
                assign v_in = pix_a_reg;
            end else begin : g_mid
                assign v_in = cell_v[k + 1];
            end
            c2dv_cell #(
                .KDIM      (KDIM),
                .MAX_WIDTH (MAX_WIDTH),
                .HAS_LINE  (k < KDIM - 1)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .ctl      (ctl),
                .rd_addr  (rd_addr),
                .wr_addr  (addr_a_reg),
                .v_in     (v_in),
                .v_out    (cell_v[k]),
                .coef_row (coef_reg[k]),
                .row_sum  (cell_sum[k])
            );
        end
    endgenerate

    always_comb begin
        total = '0;
        for (int r = 0; r < KDIM; r++) begin
            total = total + cell_sum[r];
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tdata  = {{(c2dv_pkg::TDATA_OUT_W - c2dv_pkg::SUM_W){1'b0}}, sum_reg};

endmodule

[hw/rtl/c2dv_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module c2dv_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [c2dv_pkg::TDATA_OUT_W-1:0]    m_tdata,
    input logic                                m_tlast
);

    localparam int TW = c2dv_pkg::TDATA_OUT_W;
    localparam int SW = c2dv_pkg::SUM_W;

    logic out_stall;

    assign out_stall = m_tvalid && !m_tready;

    `ASSERT_ALWAYS(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)
    `ASSERT_CLK(a_out_valid_holds, aclk, aresetn, out_stall |=> m_tvalid)
    `ASSERT_CLK(a_out_payload_holds, aclk, aresetn, out_stall |=> $stable({m_tdata, m_tlast}))
    `ASSERT_CLK(a_out_pad_zero, aclk, aresetn, m_tvalid |-> m_tdata[TW-1:SW] == '0)

endmodule

bind conv2d_valid_stream_top c2dv_checker u_c2dv_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
);

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import c2dv_pkg::*;

    localparam int KSZ           = KDIM_DEF;
    localparam int MAXW          = MAX_WIDTH_DEF;
    localparam int ROW_LIMIT     = (1 << ROW_W) - 1;
    localparam int RANDOM_ITEMS  = 950;
    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = 8;

    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] CFG_SPARE_B = 3'd7;
    localparam logic [COEF_W-1:0]     COEF_MAX    = 16'h7FFF;
    localparam logic [COEF_W-1:0]     COEF_MIN    = 16'h8000;

    typedef struct packed {
        logic signed [SUM_W-1:0] value;
        logic                    last;
    } conv_result_t;

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata   = '0;
    logic [0:0]             s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    logic [PIX_W-1:0]      line_mem [0:2][0:MAXW-1] = '{default: '0};
    logic [PIX_W-1:0]      win [0:3][0:3] = '{default: '0};
    logic [COL_W-1:0]      col_cnt    = '0;
    logic [ROW_W-1:0]      row_cnt    = '0;
    logic [DIM_W-1:0]      cfg_width  = WIDTH_RST;
    logic [DIM_W-1:0]      cfg_height = HEIGHT_RST;
    logic [CFG_DATA_W-1:0] cfg_coef [0:3] = '{default: '0};

    conv_result_t pending_sums[$];
    int           err_count    = 0;
    int           pixels_sent  = 0;
    int           src_gap_max  = 3;
    int           sink_gap_max = 3;
    int           idle_cycles  = 0;

    conv2d_valid_stream_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    function automatic int coef_of(input int r, input int j);
        logic [COEF_W-1:0] u;
        u = cfg_coef[r][COEF_W*j +: COEF_W];
        return $signed(u);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_kernel_row();
        case ($urandom_range(0, 5))
            0: return {4{COEF_MAX}};
            1: return {4{COEF_MIN}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic convolve_pixel(input logic [PIX_W-1:0] pix, input logic start);
        int unsigned  col, row, eff_w, c;
        int           k, rr, jj;
        logic [PIX_W-1:0] vcol [0:3];
        longint       acc;
        conv_result_t res;
        col   = start ? 0 : col_cnt;
        row   = start ? 0 : row_cnt;
        eff_w = (cfg_width > MAXW) ? MAXW : cfg_width;
        c     = (col < MAXW) ? col : MAXW - 1;
        for (k = 0; k < KSZ - 1; k++)
            vcol[k] = line_mem[k][c];
        vcol[KSZ-1] = pix;
        for (k = 0; k < KSZ - 1; k++)
            line_mem[k][c] = vcol[k+1];
        for (rr = 0; rr < KSZ; rr++) begin
            for (jj = 0; jj < KSZ - 1; jj++)
                win[rr][jj] = win[rr][jj+1];
            win[rr][KSZ-1] = vcol[rr];
        end
        if (eff_w >= KSZ && cfg_height >= KSZ && row + 1 >= KSZ && row < cfg_height &&
            col + 1 >= KSZ && col < eff_w) begin
            acc = 0;
            for (rr = 0; rr < KSZ; rr++)
                for (jj = 0; jj < KSZ; jj++)
                    acc += longint'(win[rr][jj]) * longint'(coef_of(rr, jj));
            res.value = acc[SUM_W-1:0];
            res.last  = (row == cfg_height - 1) && (col == eff_w - 1);
            pending_sums.push_back(res);
        end
        if (col + 1 >= eff_w) begin
            col = 0;
            row = (row < ROW_LIMIT) ? row + 1 : ROW_LIMIT;
        end else begin
            col++;
        end
        col_cnt = col[COL_W-1:0];
        row_cnt = row[ROW_W-1:0];
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic start);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        s_tuser  <= start;
        do @(posedge aclk); while (s_tready !== 1'b1);
        convolve_pixel(pix, start);
        pixels_sent++;
    endtask

    task automatic send_frame(input int count, input bit with_start, input int fill);
        int i;
        for (i = 0; i < count; i++)
            send_pixel(fill < 0 ? PIX_W'($urandom) : PIX_W'(fill), with_start && i == 0);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_sums.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_IMAGE_WIDTH:  cfg_width   = val[DIM_W-1:0];
            CFG_IMAGE_HEIGHT: cfg_height  = val[DIM_W-1:0];
            CFG_COEF_ROW0:    cfg_coef[0] = val;
            CFG_COEF_ROW1:    cfg_coef[1] = val;
            CFG_COEF_ROW2:    cfg_coef[2] = val;
            CFG_COEF_ROW3:    cfg_coef[3] = val;
            default: ;
        endcase
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h,
                             input logic [CFG_DATA_W-1:0] r0, input logic [CFG_DATA_W-1:0] r1,
                             input logic [CFG_DATA_W-1:0] r2, input logic [CFG_DATA_W-1:0] r3);
        drain();
        write_reg(CFG_IMAGE_WIDTH, w);
        write_reg(CFG_IMAGE_HEIGHT, h);
        write_reg(CFG_COEF_ROW0, r0);
        write_reg(CFG_COEF_ROW1, r1);
        write_reg(CFG_COEF_ROW2, r2);
        write_reg(CFG_COEF_ROW3, r3);
        cfg_we <= 1'b0;
    endtask

    task automatic test_no_frame_start();
        configure(5, 4, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                  rand_kernel_row());
        send_frame(20, 0, -1);
    endtask

    task automatic test_extreme_kernels();
        configure(3, 3, {4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MAX}}, {4{COEF_MIN}});
        send_frame(9, 1, 255);
        configure(3, 3, {4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}}, {4{COEF_MIN}});
        send_frame(9, 1, 255);
        send_frame(9, 1, 0);
    endtask

    task automatic test_undersized();
        int d;
        for (d = 0; d < KSZ; d++) begin
            configure(d, 4, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                      rand_kernel_row());
            send_frame(12, 1, -1);
            configure(5, d, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                      rand_kernel_row());
            send_frame(15, 1, -1);
        end
    endtask

    task automatic test_overrun_restart();
        configure(4, 3, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                  rand_kernel_row());
        send_frame(12, 1, -1);
        send_frame(8, 0, -1);
        send_frame(7, 1, -1);
        send_frame(12, 1, -1);
    endtask

    task automatic test_reg_masking();
        logic [CFG_DATA_W-1:0] val;
        drain();
        val = {$urandom, $urandom};
        val[DIM_W-1:0] = 6;
        write_reg(CFG_IMAGE_WIDTH, val);
        val = {$urandom, $urandom};
        val[DIM_W-1:0] = 3;
        write_reg(CFG_IMAGE_HEIGHT, val);
        write_reg(CFG_COEF_ROW0, rand_kernel_row());
        write_reg(CFG_COEF_ROW1, rand_kernel_row());
        write_reg(CFG_COEF_ROW2, rand_kernel_row());
        write_reg(CFG_SPARE_A, {$urandom, $urandom});
        write_reg(CFG_SPARE_B, {$urandom, $urandom});
        cfg_we <= 1'b0;
        send_frame(18, 1, -1);
        send_frame(18, 1, -1);
    endtask

    task automatic test_width_clamp();
        configure((1 << DIM_W) - 1, 3, rand_kernel_row(), rand_kernel_row(),
                  rand_kernel_row(), rand_kernel_row());
        send_frame(12 * KSZ, 1, -1);
        configure(MAXW, 3, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                  rand_kernel_row());
        send_frame(12 * KSZ, 1, -1);
    endtask

    task automatic test_random_frames();
        int first, w, h, n, i;
        first = pixels_sent;
        w = 6;
        h = 4;
        configure(w, h, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                  rand_kernel_row());
        while (pixels_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                w = $urandom_range(KSZ, 12);
                h = $urandom_range(KSZ, 7);
                case ($urandom_range(0, 7))
                    0: w = $urandom_range(0, KSZ - 1);
                    1: h = $urandom_range(0, KSZ - 1);
                    default: ;
                endcase
                configure(w, h, rand_kernel_row(), rand_kernel_row(), rand_kernel_row(),
                          rand_kernel_row());
            end
            src_gap_max  = $urandom_range(0, 1) * 3;
            sink_gap_max = $urandom_range(0, 1) * 3;
            case ($urandom_range(0, 9))
                0: send_frame($urandom_range(1, w * h), 1, -1);
                1: send_frame(w * h + $urandom_range(1, 2 * w + 2), 1, -1);
                2: begin
                    send_pixel(PIX_W'($urandom), 1'b1);
                    n = $urandom_range(1, 12);
                    for (i = 0; i < n; i++)
                        send_pixel(PIX_W'($urandom), $urandom_range(0, 3) == 0);
                end
                default: send_frame(w * h, 1, -1);
            endcase
            if ($urandom_range(0, 7) == 0)
                drain();
        end
        src_gap_max  = 3;
        sink_gap_max = 3;
    endtask

    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = $urandom_range(0, sink_gap_max);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid === 1'b1 && m_tready === 1'b1));
        end
    end

    always @(posedge aclk) begin
        conv_result_t want;
        if (aresetn && m_tvalid === 1'b1 && m_tready) begin
            if (pending_sums.size() == 0) begin
                $error("unexpected transfer: filtered_value %0d, last_of_frame %0b",
                       $signed(m_tdata[SUM_W-1:0]), m_tlast);
                err_count++;
            end else begin
                want = pending_sums.pop_front();
                if (m_tdata[SUM_W-1:0] !== want.value) begin
                    $error("filtered_value: expected %0d, actual %0d",
                           want.value, $signed(m_tdata[SUM_W-1:0]));
                    err_count++;
                end
                if (m_tlast !== want.last) begin
                    $error("last_of_frame: expected %0b, actual %0b", want.last, m_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        test_no_frame_start();
        test_extreme_kernels();
        test_undersized();
        test_overrun_restart();
        test_reg_masking();
        test_width_clamp();
        test_random_frames();
        drain();
        if (err_count == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end

endmodule
